[rtl/core/peripheral_interface_adapter_top_defines.svh]
// Assertion macros for the parallel interface adapter.
`ifndef PERIPHERAL_INTERFACE_ADAPTER_TOP_DEFINES_SVH
`define PERIPHERAL_INTERFACE_ADAPTER_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define PIA_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define PIA_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/pia_pkg.sv]
`timescale 1ns / 1ps

package pia_pkg;

  // Command codes
  localparam logic [2:0] CMD_READ    = 3'd0;
  localparam logic [2:0] CMD_WRITE   = 3'd1;
  localparam logic [2:0] CMD_SET_CA1 = 3'd2;
  localparam logic [2:0] CMD_SET_CA2 = 3'd3;
  localparam logic [2:0] CMD_SET_CB1 = 3'd4;
  localparam logic [2:0] CMD_SET_CB2 = 3'd5;
  localparam logic [2:0] CMD_RESET   = 3'd6;

  // Register select codes
  localparam logic [1:0] RS_PORT_A = 2'd0;
  localparam logic [1:0] RS_CTRL_A = 2'd1;
  localparam logic [1:0] RS_PORT_B = 2'd2;
  localparam logic [1:0] RS_CTRL_B = 2'd3;

  // Control register bit positions
  localparam int CTRL_C1_IRQ_EN = 0;
  localparam int CTRL_C1_RISING = 1;
  localparam int CTRL_SEL_DATA  = 2;
  localparam int CTRL_C2_BIT3   = 3;
  localparam int CTRL_C2_BIT4   = 4;
  localparam int CTRL_C2_OUTPUT = 5;
  localparam int CTRL_FLAG_C2   = 6;
  localparam int CTRL_FLAG_C1   = 7;

  typedef struct packed {
    logic [2:0] command;
    logic [1:0] reg_select;
    logic [7:0] write_data;
    logic       line_level;
    logic [7:0] port_a_pins;
    logic [7:0] port_b_pins;
  } pia_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] port_a_drive;
    logic [7:0] port_b_drive;
    logic       ca2_out;
    logic       cb2_out;
    logic       ca2_strobe;
    logic       cb2_strobe;
    logic       irq_a;
    logic       irq_b;
  } pia_rsp_t;

  // Operation applied to one port; at most one of the action bits is set.
  typedef struct packed {
    logic rd_data;
    logic wr_data;
    logic wr_ctrl;
    logic set_c1;
    logic set_c2;
    logic clear;
    logic strobe_on_read;
    logic strobe_on_write;
  } pia_port_op_t;

  typedef struct packed {
    logic [7:0] rd_byte;
    logic [7:0] ctrl;
    logic [7:0] drive;
    logic       c2;
    logic       strobe;
    logic       irq;
  } pia_port_stat_t;

endpackage

[rtl/core/peripheral_interface_adapter_top.sv]
`timescale 1ns / 1ps
// Channel    Signals                       Moves
// ---------  ----------------------------  ------------------------------------
// request    req_valid, req_ready, req     one command: bus access, line level, reset
// response   rsp_valid, rsp_ready, rsp     read byte, port drives, C2 levels, IRQs
//
// Every request gives exactly one response via the request and response registers.
// One request per cycle is sustained while rsp_ready stays high: the request
// register and the port state update sit in front of a single response register.
// rst (synchronous) clears both port states and empties both registers.
// A stalled response holds the response register; the request register then
// fills and req_ready drops until the response is taken.

`include "peripheral_interface_adapter_top_defines.svh"

module peripheral_interface_adapter_top import pia_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  pia_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output pia_rsp_t rsp
);

  // Request register
  logic           s1_valid;
  pia_req_t       s1;
  logic           s1_advance;

  pia_port_op_t   op_a;
  pia_port_op_t   op_b;
  pia_port_stat_t stat_a;
  pia_port_stat_t stat_b;
  pia_rsp_t       rsp_next;
  logic           is_read;
  logic           is_write;

  // Advance the request into the response register when that register is
  // empty or being drained in this cycle.
  assign s1_advance = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready  = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  // Payload needs no reset; load on every transfer.
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1 <= req;
    end
  end

  // Decode the command into one operation per port.
  assign is_read  = (s1.command == CMD_READ);
  assign is_write = (s1.command == CMD_WRITE);

  always_comb begin
    op_a.rd_data         = is_read && (s1.reg_select == RS_PORT_A);
    op_a.wr_data         = is_write && (s1.reg_select == RS_PORT_A);
    op_a.wr_ctrl         = is_write && (s1.reg_select == RS_CTRL_A);
    op_a.set_c1          = (s1.command == CMD_SET_CA1);
    op_a.set_c2          = (s1.command == CMD_SET_CA2);
    op_a.clear           = (s1.command == CMD_RESET);
    op_a.strobe_on_read  = 1'b1;   // CA2 strobes on port A reads
    op_a.strobe_on_write = 1'b0;

    op_b.rd_data         = is_read && (s1.reg_select == RS_PORT_B);
    op_b.wr_data         = is_write && (s1.reg_select == RS_PORT_B);
    op_b.wr_ctrl         = is_write && (s1.reg_select == RS_CTRL_B);
    op_b.set_c1          = (s1.command == CMD_SET_CB1);
    op_b.set_c2          = (s1.command == CMD_SET_CB2);
    op_b.clear           = (s1.command == CMD_RESET);
    op_b.strobe_on_read  = 1'b0;
    op_b.strobe_on_write = 1'b1;   // CB2 strobes on port B writes
  end

  pia_port u_port_a (
    .clk        (clk),
    .rst        (rst),
    .en         (s1_advance),
    .op         (op_a),
    .write_data (s1.write_data),
    .level      (s1.line_level),
    .pins       (s1.port_a_pins),
    .stat       (stat_a)
  );

  pia_port u_port_b (
    .clk        (clk),
    .rst        (rst),
    .en         (s1_advance),
    .op         (op_b),
    .write_data (s1.write_data),
    .level      (s1.line_level),
    .pins       (s1.port_b_pins),
    .stat       (stat_b)
  );

  // Assemble the response; read data is zero for anything but a bus read.
  always_comb begin
    rsp_next.read_data = '0;
    if (is_read) begin
      case (s1.reg_select)
        RS_PORT_A: rsp_next.read_data = stat_a.rd_byte;
        RS_CTRL_A: rsp_next.read_data = stat_a.ctrl;
        RS_PORT_B: rsp_next.read_data = stat_b.rd_byte;
        RS_CTRL_B: rsp_next.read_data = stat_b.ctrl;
        default:   rsp_next.read_data = '0;
      endcase
    end
    rsp_next.port_a_drive = stat_a.drive;
    rsp_next.port_b_drive = stat_b.drive;
    rsp_next.ca2_out      = stat_a.c2;
    rsp_next.cb2_out      = stat_b.c2;
    rsp_next.ca2_strobe   = stat_a.strobe;
    rsp_next.cb2_strobe   = stat_b.strobe;
    rsp_next.irq_a        = stat_a.irq;
    rsp_next.irq_b        = stat_b.irq;
  end

  // Response register: hold while stalled, drop the valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      rsp <= rsp_next;
    end
  end

  // A pulse strobe always leaves C2 back high.
  `PIA_CHECK(a_ca2_strobe_high, rsp_valid && rsp.ca2_strobe |-> rsp.ca2_out, "CA2 strobe left low")
  `PIA_CHECK(a_cb2_strobe_high, rsp_valid && rsp.cb2_strobe |-> rsp.cb2_out, "CB2 strobe left low")
  // Only a bus read returns a nonzero byte.
  `PIA_CHECK(a_read_data_zero,
    s1_advance && (s1.command != CMD_READ) |=> rsp.read_data == 8'h00,
    "read data nonzero on non-read")
  // A reset command leaves both ports as inputs with IRQs released.
  `PIA_CHECK(a_reset_cmd,
    s1_advance && (s1.command == CMD_RESET) |=>
      rsp.port_a_drive == 8'hFF && rsp.port_b_drive == 8'hFF && !rsp.irq_a && !rsp.irq_b,
    "reset command left state behind")
  // Both the request and the response register are empty following reset.
  `PIA_CHECK_ALWAYS(a_rst_empty, $past(rst) |-> !s1_valid && !rsp_valid,
    "pipeline not empty after reset")

endmodule

[rtl/core/pia_port.sv]
`timescale 1ns / 1ps

module pia_port import pia_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  pia_port_op_t   op,
  input  logic [7:0]     write_data,
  input  logic           level,
  input  logic [7:0]     pins,
  output pia_port_stat_t stat
);

  logic [7:0] ctrl, ctrl_next;
  logic [7:0] dir, dir_next;
  logic [7:0] outr, outr_next;
  logic       c1, c1_next;
  logic       c2, c2_next;
  logic       strobe;
  logic       strobe_mode;
  logic       c1_edge;
  logic       c2_edge;
  logic [7:0] rd_byte;

  always_comb begin
    ctrl_next   = ctrl;
    dir_next    = dir;
    outr_next   = outr;
    c1_next     = c1;
    c2_next     = c2;
    strobe      = 1'b0;
    // pulse/handshake: C2 output, not direct, data register selected
    strobe_mode = ctrl[CTRL_SEL_DATA] && ctrl[CTRL_C2_OUTPUT] && !ctrl[CTRL_C2_BIT4];
    c1_edge     = ctrl[CTRL_C1_RISING] ? (!c1 && level) : (c1 && !level);
    c2_edge     = ctrl[CTRL_C2_BIT4] ? (!c2 && level) : (c2 && !level);
    rd_byte     = ctrl[CTRL_SEL_DATA] ? ((outr & dir) | (pins & ~dir)) : dir;

    if (op.clear) begin
      ctrl_next = '0;
      dir_next  = '0;
      outr_next = '0;
      c1_next   = 1'b0;
      c2_next   = 1'b0;
    end else begin
      if (op.rd_data) begin
        if (ctrl[CTRL_SEL_DATA]) begin
          ctrl_next[CTRL_FLAG_C1] = 1'b0;
          ctrl_next[CTRL_FLAG_C2] = 1'b0;
        end
        if (op.strobe_on_read && strobe_mode) begin
          c2_next = ctrl[CTRL_C2_BIT3];
          strobe  = ctrl[CTRL_C2_BIT3];
        end
      end
      if (op.wr_data) begin
        if (ctrl[CTRL_SEL_DATA]) begin
          outr_next = write_data;
        end else begin
          dir_next = write_data;
        end
        if (op.strobe_on_write && strobe_mode) begin
          c2_next = ctrl[CTRL_C2_BIT3];
          strobe  = ctrl[CTRL_C2_BIT3];
        end
      end
      if (op.wr_ctrl) begin
        // flags are read-only
        ctrl_next = {ctrl[CTRL_FLAG_C1], ctrl[CTRL_FLAG_C2], write_data[5:0]};
        if (write_data[CTRL_C2_OUTPUT] && write_data[CTRL_C2_BIT4]) begin
          c2_next = write_data[CTRL_C2_BIT3];
        end
      end
      if (op.set_c1) begin
        if (c1_edge) begin
          if (ctrl[CTRL_C1_IRQ_EN]) begin
            ctrl_next[CTRL_FLAG_C1] = 1'b1;
          end
          // end of handshake
          if (ctrl[CTRL_C2_OUTPUT] && !ctrl[CTRL_C2_BIT4] && !ctrl[CTRL_C2_BIT3]) begin
            c2_next = 1'b1;
          end
        end
        c1_next = level;
      end
      if (op.set_c2) begin
        if (!ctrl[CTRL_C2_OUTPUT] && ctrl[CTRL_C2_BIT3] && c2_edge) begin
          ctrl_next[CTRL_FLAG_C2] = 1'b1;
        end
        c2_next = level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
      dir  <= '0;
      outr <= '0;
      c1   <= 1'b0;
      c2   <= 1'b0;
    end else if (en) begin
      ctrl <= ctrl_next;
      dir  <= dir_next;
      outr <= outr_next;
      c1   <= c1_next;
      c2   <= c2_next;
    end
  end

  assign stat.rd_byte = rd_byte;
  assign stat.ctrl    = ctrl;
  assign stat.drive   = (outr_next & dir_next) | ~dir_next;
  assign stat.c2      = c2_next;
  assign stat.strobe  = strobe;
  assign stat.irq     = ctrl_next[CTRL_FLAG_C1] | ctrl_next[CTRL_FLAG_C2];

endmodule

[tb/tb_peripheral_interface_adapter_top.sv]
`timescale 1ns / 1ps

module tb_peripheral_interface_adapter_top;
  import pia_pkg::*;

  // Command code that the block decodes as "do nothing, report the state".
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  // Index into the port state array.
  localparam int PORT_A = 0;
  localparam int PORT_B = 1;

  // Give up after this many clocks; a correct run needs a small fraction.
  localparam int CYCLE_LIMIT = 300000;

  // Receiver hold-off length in cycles, and spacing in responses.
  localparam int HOLD_CYCLES = 60;
  localparam int HOLD_SPACING = 400;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_ready;
  pia_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_ready = 1'b0;
  pia_rsp_t rsp;

  peripheral_interface_adapter_top dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Port state mirror: control, direction and output registers plus the last
  // seen C1/C2 levels, one entry per port.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [7:0] ctrl;
    logic [7:0] dir;
    logic [7:0] outr;
    logic       c1;
    logic       c2;
  } port_regs_t;

  port_regs_t port_regs [2] = '{default: '0};

  // A command waiting for the driver; settle_first makes the sender hold off
  // until every outstanding response has come back.
  typedef struct {
    pia_req_t cmd;
    bit       settle_first;
  } backlog_entry_t;

  backlog_entry_t cmd_backlog [$];
  pia_rsp_t       pending_rsp [$];

  int errors = 0;
  int cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int rx_seen = 0;
  int hold_left = 0;
  int next_hold_at = 200;
  int phase_cnt = 0;
  int stall_mode = 0;

  function automatic logic active_edge(logic old_lvl, logic new_lvl, logic rising);
    return rising ? (!old_lvl && new_lvl) : (old_lvl && !new_lvl);
  endfunction

  function automatic logic [7:0] port_drive(int p);
    return (port_regs[p].outr & port_regs[p].dir) | ~port_regs[p].dir;
  endfunction

  // Data read: give the DDR when it is selected, else merge output and pin
  // bits and clear both flags.
  function automatic logic [7:0] read_port(int p, logic [7:0] pins);
    if (!port_regs[p].ctrl[CTRL_SEL_DATA]) return port_regs[p].dir;
    port_regs[p].ctrl[CTRL_FLAG_C1] = 1'b0;
    port_regs[p].ctrl[CTRL_FLAG_C2] = 1'b0;
    return (port_regs[p].outr & port_regs[p].dir) | (pins & ~port_regs[p].dir);
  endfunction

  function automatic void write_port(int p, logic [7:0] v);
    if (port_regs[p].ctrl[CTRL_SEL_DATA]) port_regs[p].outr = v;
    else port_regs[p].dir = v;
  endfunction

  // Flags stay; only bits 5..0 load. Direct mode drives C2 from bit 3.
  function automatic void write_ctrl(int p, logic [7:0] v);
    port_regs[p].ctrl = {port_regs[p].ctrl[7:6], v[5:0]};
    if (v[CTRL_C2_OUTPUT] && v[CTRL_C2_BIT4]) port_regs[p].c2 = v[CTRL_C2_BIT3];
  endfunction

  // Pulse mode raises C2 again at once and reports the pulse; handshake mode
  // leaves C2 low until the next active C1 edge.
  function automatic logic fire_strobe(int p);
    if (!port_regs[p].ctrl[CTRL_C2_OUTPUT] || port_regs[p].ctrl[CTRL_C2_BIT4]) return 1'b0;
    if (port_regs[p].ctrl[CTRL_C2_BIT3]) begin
      port_regs[p].c2 = 1'b1;
      return 1'b1;
    end
    port_regs[p].c2 = 1'b0;
    return 1'b0;
  endfunction

  function automatic void move_c1(int p, logic lvl);
    if (active_edge(port_regs[p].c1, lvl, port_regs[p].ctrl[CTRL_C1_RISING])) begin
      if (port_regs[p].ctrl[CTRL_C1_IRQ_EN]) port_regs[p].ctrl[CTRL_FLAG_C1] = 1'b1;
      if ({port_regs[p].ctrl[CTRL_C2_OUTPUT], port_regs[p].ctrl[CTRL_C2_BIT4],
           port_regs[p].ctrl[CTRL_C2_BIT3]} == 3'b100)
        port_regs[p].c2 = 1'b1;
    end
    port_regs[p].c1 = lvl;
  endfunction

  function automatic void move_c2(int p, logic lvl);
    if (!port_regs[p].ctrl[CTRL_C2_OUTPUT] && port_regs[p].ctrl[CTRL_C2_BIT3] &&
        active_edge(port_regs[p].c2, lvl, port_regs[p].ctrl[CTRL_C2_BIT4]))
      port_regs[p].ctrl[CTRL_FLAG_C2] = 1'b1;
    port_regs[p].c2 = lvl;
  endfunction

  // Advance the port mirror by one command and return the response it gives.
  function automatic pia_rsp_t pia_next_response(pia_req_t r);
    pia_rsp_t e;
    logic     sel;
    e = '0;
    case (r.command)
      CMD_READ: begin
        case (r.reg_select)
          RS_PORT_A: begin
            sel = port_regs[PORT_A].ctrl[CTRL_SEL_DATA];
            e.read_data = read_port(PORT_A, r.port_a_pins);
            if (sel) e.ca2_strobe = fire_strobe(PORT_A);
          end
          RS_CTRL_A: e.read_data = port_regs[PORT_A].ctrl;
          RS_PORT_B: e.read_data = read_port(PORT_B, r.port_b_pins);
          default:   e.read_data = port_regs[PORT_B].ctrl;
        endcase
      end
      CMD_WRITE: begin
        case (r.reg_select)
          RS_PORT_A: write_port(PORT_A, r.write_data);
          RS_CTRL_A: write_ctrl(PORT_A, r.write_data);
          RS_PORT_B: begin
            sel = port_regs[PORT_B].ctrl[CTRL_SEL_DATA];
            write_port(PORT_B, r.write_data);
            if (sel) e.cb2_strobe = fire_strobe(PORT_B);
          end
          default:   write_ctrl(PORT_B, r.write_data);
        endcase
      end
      CMD_SET_CA1: move_c1(PORT_A, r.line_level);
      CMD_SET_CA2: move_c2(PORT_A, r.line_level);
      CMD_SET_CB1: move_c1(PORT_B, r.line_level);
      CMD_SET_CB2: move_c2(PORT_B, r.line_level);
      CMD_RESET: begin
        port_regs[PORT_A] = '0;
        port_regs[PORT_B] = '0;
      end
      default: ;
    endcase
    e.port_a_drive = port_drive(PORT_A);
    e.port_b_drive = port_drive(PORT_B);
    e.ca2_out = port_regs[PORT_A].c2;
    e.cb2_out = port_regs[PORT_B].c2;
    e.irq_a = |port_regs[PORT_A].ctrl[7:6];
    e.irq_b = |port_regs[PORT_B].ctrl[7:6];
    return e;
  endfunction

  task automatic backlog_push(logic [2:0] cmd, logic [1:0] rs, logic [7:0] wd, logic lvl,
                              logic [7:0] pins_a, logic [7:0] pins_b, bit settle);
    backlog_entry_t b;
    b.cmd = '{command: cmd, reg_select: rs, write_data: wd, line_level: lvl,
              port_a_pins: pins_a, port_b_pins: pins_b};
    b.settle_first = settle;
    cmd_backlog.push_back(b);
  endtask

  task automatic push_random(logic [2:0] cmd, logic [1:0] rs, logic [7:0] wd, bit settle);
    backlog_push(cmd, rs, wd, 1'($urandom), 8'($urandom), 8'($urandom), settle);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present the head of the backlog in bursts of random length with
  // random gaps; hold valid and payload steady until the transfer happens.
  // Predict each response at the moment its request transfers.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic took;
    logic show;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      took = req_valid && req_ready;
      show = 1'b0;
      if (took) begin
        pending_rsp.push_back(pia_next_response(req));
        cmd_backlog.delete(0);
        burst_left--;
        // Some bursts end with no gap at all, so back-to-back runs occur too.
        if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (req_valid && !took) begin
        show = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_backlog.size() > 0 &&
                   !(cmd_backlog[0].settle_first && pending_rsp.size() != 0)) begin
        if (burst_left == 0)
          burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 12);
        req <= cmd_backlog[0].cmd;
        show = 1'b1;
      end
      req_valid <= show;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall on one of four patterns picked at random, and now and
  // then hold off for a long stretch so the block fills and drops req_ready.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) rx_seen++;
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (rx_seen >= next_hold_at) begin
        hold_left = HOLD_CYCLES;
        next_hold_at += HOLD_SPACING;
        rsp_ready <= 1'b0;
      end else begin
        phase_cnt++;
        if (phase_cnt == 64) begin
          phase_cnt = 0;
          stall_mode = $urandom_range(0, 3);
        end
        case (stall_mode)
          0:       rsp_ready <= 1'b1;
          1:       rsp_ready <= 1'($urandom_range(0, 1));
          2:       rsp_ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ready <= ~rsp_ready;
        endcase
      end
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: compare each response transfer with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pia_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response: expected none, actual %h", $time, rsp);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        check_field("read_data", want.read_data, rsp.read_data);
        check_field("port_a_drive", want.port_a_drive, rsp.port_a_drive);
        check_field("port_b_drive", want.port_b_drive, rsp.port_b_drive);
        check_field("ca2_out", 8'(want.ca2_out), 8'(rsp.ca2_out));
        check_field("cb2_out", 8'(want.cb2_out), 8'(rsp.cb2_out));
        check_field("ca2_strobe", 8'(want.ca2_strobe), 8'(rsp.ca2_strobe));
        check_field("cb2_strobe", 8'(want.cb2_strobe), 8'(rsp.cb2_strobe));
        check_field("irq_a", 8'(want.irq_a), 8'(rsp.irq_a));
        check_field("irq_b", 8'(want.irq_b), 8'(rsp.irq_b));
      end
    end
  end

  // Drop the run if it hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: a directed walk through every register, mode and special case,
  // then random traffic of single commands mixed with short strobe and C2 edge sequences.
  // ---------------------------------------------------------------------------
  initial begin
    int         n;
    int         k;
    int         p;
    bit         settle;
    bit         mid_pause_done;
    logic [7:0] cv;
    logic [1:0] rs_ctrl;
    logic [1:0] rs_data;

    // DDR read at reset, then DDR writes at both extremes.
    backlog_push(CMD_READ, RS_PORT_A, 8'h00, 1'b0, 8'hFF, 8'h00, 1'b0);
    backlog_push(CMD_WRITE, RS_PORT_A, 8'hFF, 1'b0, 8'h00, 8'hFF, 1'b0);
    backlog_push(CMD_WRITE, RS_PORT_B, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0);
    // All ones into control A: flag bits must not load; direct mode sets CA2.
    backlog_push(CMD_WRITE, RS_CTRL_A, 8'hFF, 1'b1, 8'hFF, 8'hFF, 1'b0);
    backlog_push(CMD_WRITE, RS_PORT_A, 8'hA5, 1'b0, 8'h5A, 8'h5A, 1'b0);
    backlog_push(CMD_READ, RS_CTRL_A, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0);
    // Rising CA1 edge with the interrupt enabled sets flag 7.
    backlog_push(CMD_SET_CA1, RS_PORT_A, 8'h00, 1'b1, 8'h00, 8'h00, 1'b0);
    // Control write keeps the flag; a DDR read does not clear it.
    backlog_push(CMD_WRITE, RS_CTRL_A, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0);
    backlog_push(CMD_READ, RS_PORT_A, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0);
    backlog_push(CMD_READ, RS_CTRL_A, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0);
    // Pulse mode: a port A data read clears the flags and strobes CA2.
    backlog_push(CMD_WRITE, RS_CTRL_A, 8'h2C, 1'b0, 8'h00, 8'h00, 1'b0);
    backlog_push(CMD_READ, RS_PORT_A, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0);
    // Handshake mode: the read drops CA2, a falling CA1 edge raises it.
    backlog_push(CMD_WRITE, RS_CTRL_A, 8'h25, 1'b0, 8'h00, 8'h00, 1'b0);
    backlog_push(CMD_READ, RS_PORT_A, 8'h00, 1'b0, 8'hFF, 8'h00, 1'b0);
    backlog_push(CMD_SET_CA1, RS_PORT_A, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0);
    // CB2 as input, rising edge armed: the edge sets flag 6, the read clears.
    backlog_push(CMD_WRITE, RS_CTRL_B, 8'h1C, 1'b0, 8'h00, 8'h00, 1'b0);
    backlog_push(CMD_SET_CB2, RS_PORT_B, 8'h00, 1'b1, 8'h00, 8'h00, 1'b0);
    backlog_push(CMD_READ, RS_PORT_B, 8'h00, 1'b0, 8'h00, 8'hFF, 1'b0);
    // Port B write strobe, pulse and then handshake ended by CB1.
    backlog_push(CMD_WRITE, RS_CTRL_B, 8'h2C, 1'b0, 8'h00, 8'h00, 1'b0);
    backlog_push(CMD_WRITE, RS_PORT_B, 8'h5A, 1'b0, 8'h00, 8'h00, 1'b0);
    backlog_push(CMD_WRITE, RS_CTRL_B, 8'h24, 1'b0, 8'h00, 8'h00, 1'b0);
    backlog_push(CMD_WRITE, RS_PORT_B, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0);
    backlog_push(CMD_SET_CB1, RS_PORT_B, 8'h00, 1'b1, 8'h00, 8'h00, 1'b0);
    backlog_push(CMD_SET_CB1, RS_PORT_B, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0);
    // Level stored on CA2 in output mode, the unused code, then a reset.
    backlog_push(CMD_SET_CA2, RS_PORT_A, 8'h00, 1'b1, 8'h00, 8'h00, 1'b0);
    backlog_push(CMD_UNUSED, RS_CTRL_B, 8'hFF, 1'b1, 8'hFF, 8'hFF, 1'b0);
    backlog_push(CMD_RESET, RS_PORT_A, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0);

    // Random part; let the block drain before it starts and once midway.
    n = 0;
    settle = 1'b1;
    mid_pause_done = 1'b0;
    while (n < 1050) begin
      if (n >= 500 && !mid_pause_done) begin
        settle = 1'b1;
        mid_pause_done = 1'b1;
      end
      p = $urandom_range(0, 1);
      rs_ctrl = (p == PORT_A) ? RS_CTRL_A : RS_CTRL_B;
      rs_data = (p == PORT_A) ? RS_PORT_A : RS_PORT_B;
      k = $urandom_range(0, 99);
      if (k < 20) begin
        // C2 output strobe: arm, access data, toggle C1, read back.
        cv = 8'($urandom);
        cv[CTRL_C2_OUTPUT] = 1'b1;
        cv[CTRL_C2_BIT4] = ($urandom_range(0, 3) == 0);
        cv[CTRL_SEL_DATA] = 1'b1;
        push_random(CMD_WRITE, rs_ctrl, cv, settle);
        settle = 1'b0;
        push_random((p == PORT_A) ? CMD_READ : CMD_WRITE, rs_data, 8'($urandom), 1'b0);
        push_random((p == PORT_A) ? CMD_SET_CA1 : CMD_SET_CB1, rs_data, 8'($urandom), 1'b0);
        push_random((p == PORT_A) ? CMD_SET_CA1 : CMD_SET_CB1, rs_data, 8'($urandom), 1'b0);
        push_random(CMD_READ, rs_ctrl, 8'($urandom), 1'b0);
        push_random(CMD_READ, rs_data, 8'($urandom), 1'b0);
        n += 6;
      end else if (k < 30) begin
        // C2 input edges with the interrupt armed, then read the flags.
        cv = 8'($urandom);
        cv[CTRL_C2_OUTPUT] = 1'b0;
        cv[CTRL_C2_BIT3] = 1'b1;
        push_random(CMD_WRITE, rs_ctrl, cv, settle);
        settle = 1'b0;
        repeat (3)
          push_random((p == PORT_A) ? CMD_SET_CA2 : CMD_SET_CB2, rs_data, 8'($urandom), 1'b0);
        push_random(CMD_READ, rs_ctrl, 8'($urandom), 1'b0);
        n += 5;
      end else begin
        k = $urandom_range(0, 99);
        if (k < 4) begin
          push_random(3'($urandom_range(0, 7)), 2'($urandom), 8'($urandom), settle);
        end else if (k < 5) begin
          push_random(CMD_RESET, 2'($urandom), 8'($urandom), settle);
        end else if (k < 35) begin
          push_random(CMD_READ, 2'($urandom), 8'($urandom), settle);
        end else if (k < 60) begin
          p = $urandom_range(0, 3);
          cv = 8'($urandom);
          if ((p == RS_CTRL_A || p == RS_CTRL_B) && $urandom_range(0, 9) < 7)
            cv[CTRL_SEL_DATA] = 1'b1;
          push_random(CMD_WRITE, 2'(p), cv, settle);
        end else begin
          push_random(3'(CMD_SET_CA1 + $urandom_range(0, 3)), 2'($urandom), 8'($urandom),
                      settle);
        end
        settle = 1'b0;
        n++;
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait for every command to transfer and every response to come back,
    // then keep watching so that any stray response still shows.
    while (cmd_backlog.size() != 0 || pending_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
